>>> hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared definitions of the ultrasonic echo ranger
// Opcodes, register indexes, arithmetic constants and the command, status
// and result types shared between the controller, datapath and top level.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int STAMP_BITS = 32;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] OP_TRIGGER  = 2'd0;
  localparam logic [1:0] OP_CAPTURE  = 2'd1;
  localparam logic [1:0] OP_OVERFLOW = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DISTANCE = 2'd2;

  localparam logic [16:0] WRAP_RESET    = 17'd65535;
  localparam logic [9:0]  TIMEOUT_RESET = 10'd60;
  localparam logic [15:0] OPEN_RESET    = 16'd45000;

  localparam int DIST_LIMIT = 45000;
  // Smallest width whose scaled distance exceeds the limit.
  localparam int SAT_WIDTH  = (DIST_LIMIT * 10 + 10 + 16) / 17;
  localparam int SMALL_W    = 15;
  localparam int SCALED_W   = 19;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP      = (1 << RECIP_SHIFT) / 10 + 1;

  typedef logic [STAMP_BITS-1:0] stamp_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul;
    logic sub;
    logic scale;
    logic div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic second_edge;
  } status_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        measure_done;
    logic        timed_out;
    logic        trigger_fired;
    logic        busy_res;
    logic        edge_phase;
  } out_item_t;

endpackage

>>> hw/rtl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if: stream channels of the ultrasonic echo ranger
// Valid/ready channels for timer events and for ranging results.
// ----------------------------------------------------------------------------
interface uer_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] capture_value;

  modport source (output valid, output opcode, output capture_value, input ready);
  modport sink (input valid, input opcode, input capture_value, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic        measure_done;
  logic        timed_out;
  logic        trigger_fired;
  logic        busy_res;
  logic        edge_phase;

  modport source (output valid, output distance, output measure_done, output timed_out,
                  output trigger_fired, output busy_res, output edge_phase, input ready);
  modport sink (input valid, input distance, input measure_done, input timed_out,
                input trigger_fired, input busy_res, input edge_phase, output ready);
endinterface

>>> hw/rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl: sequencing controller
// Accepts one event, steps the datapath through the event update or the
// distance computation, and hands the result to the output register.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  uer_pkg::status_t status,
  output uer_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.second_edge) begin
          state_nxt = S_MUL;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted transaction did not start execution");

  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_OUT))
    else $error("distance computation did not finish");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result presented outside the output step");

endmodule

>>> hw/rtl/uer_dp.sv
// ----------------------------------------------------------------------------
// uer_dp: ranging datapath
// Holds the configuration and measurement state, applies event updates and
// computes the echo width and distance in registered steps.
// ----------------------------------------------------------------------------
module uer_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                         in_opcode,
  input  logic [15:0]                        in_capture_value,
  input  uer_pkg::cmd_t                      cmd,
  output uer_pkg::status_t                   status,
  output uer_pkg::out_item_t                 out_item
);

  logic [16:0]  wrap_r;
  logic [9:0]   timeout_r;
  logic [15:0]  open_r;

  logic [1:0]   op_r;
  logic [15:0]  cap_r;
  logic         phase_r;
  logic [15:0]  rise_r;
  logic [15:0]  ovf_r;
  logic         pending_r;
  logic [15:0]  elapsed_r;
  logic [15:0]  dist_r;
  logic         done_r, tout_r, fired_r;

  logic [32:0]                      prod_r;
  uer_pkg::stamp_t                  width_r;
  logic                             sat_r;
  logic [uer_pkg::SCALED_W-1:0]     scaled_r;
  uer_pkg::out_item_t               out_r;

  logic [15:0]                      el_inc;
  logic [2*uer_pkg::SCALED_W-1:0]   qprod;

  assign status.second_edge = (op_r == uer_pkg::OP_CAPTURE) && phase_r;
  assign out_item = out_r;

  assign el_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign qprod  = {{uer_pkg::SCALED_W{1'b0}}, scaled_r}
                * (2*uer_pkg::SCALED_W)'(uer_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r    <= uer_pkg::WRAP_RESET;
      timeout_r <= uer_pkg::TIMEOUT_RESET;
      open_r    <= uer_pkg::OPEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::REG_WRAP_COUNT:    wrap_r    <= cfg_data;
        uer_pkg::REG_TIMEOUT_MS:    timeout_r <= cfg_data[9:0];
        uer_pkg::REG_OPEN_DISTANCE: open_r    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      rise_r    <= '0;
      ovf_r     <= '0;
      pending_r <= 1'b0;
      elapsed_r <= '0;
      dist_r    <= '0;
      done_r    <= 1'b0;
      tout_r    <= 1'b0;
      fired_r   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        done_r  <= 1'b0;
        tout_r  <= 1'b0;
        fired_r <= 1'b0;
      end
      if (cmd.exec) begin
        case (op_r)
          uer_pkg::OP_TRIGGER: begin
            if (!pending_r) begin
              pending_r <= 1'b1;
              elapsed_r <= '0;
              fired_r   <= 1'b1;
            end
          end
          uer_pkg::OP_CAPTURE: begin
            rise_r  <= cap_r;
            ovf_r   <= '0;
            phase_r <= 1'b1;
          end
          uer_pkg::OP_OVERFLOW: begin
            ovf_r <= ovf_r + 16'd1;
          end
          default: begin
            elapsed_r <= el_inc;
            if (pending_r && (el_inc >= {6'b0, timeout_r})) begin
              dist_r    <= open_r;
              phase_r   <= 1'b0;
              ovf_r     <= '0;
              pending_r <= 1'b0;
              tout_r    <= 1'b1;
            end
          end
        endcase
      end
      if (cmd.div) begin
        dist_r    <= sat_r ? 16'(uer_pkg::DIST_LIMIT)
                           : qprod[uer_pkg::RECIP_SHIFT +: 16];
        pending_r <= 1'b0;
        phase_r   <= 1'b0;
        done_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      cap_r <= in_capture_value;
    end
    if (cmd.mul) begin
      prod_r <= {17'b0, ovf_r} * {16'b0, wrap_r};
    end
    if (cmd.sub) begin
      width_r <= uer_pkg::stamp_t'(cap_r) + uer_pkg::stamp_t'(prod_r)
               - uer_pkg::stamp_t'(rise_r);
    end
    if (cmd.scale) begin
      sat_r    <= width_r >= uer_pkg::stamp_t'(uer_pkg::SAT_WIDTH);
      scaled_r <= {width_r[uer_pkg::SMALL_W-1:0], 4'b0}
                + {4'b0, width_r[uer_pkg::SMALL_W-1:0]};
    end
    if (cmd.load_out) begin
      out_r.distance      <= dist_r;
      out_r.measure_done  <= done_r;
      out_r.timed_out     <= tout_r;
      out_r.trigger_fired <= fired_r;
      out_r.busy_res      <= pending_r;
      out_r.edge_phase    <= phase_r;
    end
  end

endmodule

>>> hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo pulse-width ranging from timer events
// Top level joining the sequencing controller and the ranging datapath.
// ----------------------------------------------------------------------------
// Each accepted timer event yields one result transaction. Triggers, first
// capture edges, overflow counts and millisecond ticks go from the event
// update step straight to the output step; a second capture edge is stepped
// by the controller through the overflow multiply, the width subtraction,
// the scaling by 17 and the reciprocal divide by 10, one register each,
// before its output step. One event is in flight at a time; the result sits
// in an output register, so the next event is accepted while it waits to be
// taken, and a result that is not taken stalls the following event in its
// output step.
// Configuration writes take effect at once and belong to idle periods.
module ultrasonic_echo_ranger (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
  uer_in_if.sink                          in_ch,
  uer_out_if.source                       out_ch
);

  uer_pkg::cmd_t      cmd;
  uer_pkg::status_t   status;
  uer_pkg::out_item_t out_item;

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  uer_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_ch.opcode),
    .in_capture_value (in_ch.capture_value),
    .cmd              (cmd),
    .status           (status),
    .out_item         (out_item)
  );

  assign out_ch.distance      = out_item.distance;
  assign out_ch.measure_done  = out_item.measure_done;
  assign out_ch.timed_out     = out_item.timed_out;
  assign out_ch.trigger_fired = out_item.trigger_fired;
  assign out_ch.busy_res      = out_item.busy_res;
  assign out_ch.edge_phase    = out_item.edge_phase;

endmodule

>>> verif/tb_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger: self-checking bench for the echo ranger
// Sends timer events (triggers, capture edges, counter overflows and
// millisecond ticks) through the valid/ready input channel and checks every
// result against an in-bench model of the ranging logic or, for typed rows,
// against table values. A short directed table covers reset values,
// saturation, timeouts and wrap cases; random echo sequences with noise
// follow under several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int BLOCK_ITEMS  = 110;
  localparam int N_DIR        = 27;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  op;
    logic [15:0] cap;
    logic [16:0] wrap;
    logic [9:0]  tmo;
    logic [15:0] open_d;
    logic        typed;
    out_item_t   exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  uer_in_if  in_ch ();
  uer_out_if out_ch ();

  ultrasonic_echo_ranger uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Model state and register copies.
  logic        awaiting_fall;
  logic [31:0] rise_ts;
  logic [15:0] ovf_cnt;
  logic        armed;
  logic [15:0] ms_elapsed;
  logic [15:0] dist_q;
  logic [16:0] wrap_cfg;
  logic [9:0]  timeout_cfg;
  logic [15:0] open_cfg;

  out_item_t expected_ranges [$];
  stim_row_t dir_rows [N_DIR];

  int err_count      = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int done_count     = 0;
  int timeout_count  = 0;
  int cfg_writes     = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t range_step(logic [1:0] op, logic [15:0] cap);
    out_item_t   r;
    logic [31:0] width;
    logic [63:0] scaled;
    r = '0;
    case (op)
      OP_TRIGGER: begin
        if (!armed) begin
          armed = 1'b1;
          ms_elapsed = '0;
          r.trigger_fired = 1'b1;
        end
      end
      OP_CAPTURE: begin
        if (!awaiting_fall) begin
          rise_ts = {16'h0, cap};
          ovf_cnt = '0;
          awaiting_fall = 1'b1;
        end else begin
          width = {16'h0, cap} + 32'(ovf_cnt) * 32'(wrap_cfg) - rise_ts;
          scaled = 64'(width) * 64'd17 / 64'd10;
          dist_q = (scaled > 64'(DIST_LIMIT)) ? 16'(DIST_LIMIT) : scaled[15:0];
          armed = 1'b0;
          awaiting_fall = 1'b0;
          r.measure_done = 1'b1;
        end
      end
      OP_OVERFLOW: begin
        ovf_cnt = ovf_cnt + 16'd1;
      end
      default: begin
        if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
        if (armed && ms_elapsed >= 16'(timeout_cfg)) begin
          dist_q = open_cfg;
          awaiting_fall = 1'b0;
          ovf_cnt = '0;
          armed = 1'b0;
          r.timed_out = 1'b1;
        end
      end
    endcase
    r.distance = dist_q;
    r.busy_res = armed;
    r.edge_phase = awaiting_fall;
    return r;
  endfunction

  function automatic stim_row_t ev_row(logic [1:0] op, logic [15:0] cap);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.cap = cap;
    return r;
  endfunction

  function automatic stim_row_t ev_row_x(logic [1:0] op, logic [15:0] cap, out_item_t e);
    stim_row_t r;
    r = ev_row(op, cap);
    r.typed = 1'b1;
    r.exp = e;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [16:0] wrap, logic [9:0] tmo,
                                        logic [15:0] open_d);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.wrap = wrap;
    r.tmo = tmo;
    r.open_d = open_d;
    return r;
  endfunction

  function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  task automatic send_event(logic [1:0] op, logic [15:0] cap, bit typed = 1'b0,
                            out_item_t typed_exp = '0);
    out_item_t predicted;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.capture_value <= cap;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = range_step(op, cap);
    expected_ranges.push_back(typed ? typed_exp : predicted);
    sent_count++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [16:0] wrap, logic [9:0] tmo, logic [15:0] open_d);
    cfg_we <= 1'b1;
    cfg_index <= REG_WRAP_COUNT;
    cfg_data <= wrap;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_MS;
    cfg_data <= 17'(tmo);
    @(posedge clk);
    cfg_index <= REG_OPEN_DISTANCE;
    cfg_data <= 17'(open_d);
    @(posedge clk);
    cfg_we <= 1'b0;
    wrap_cfg = wrap;
    timeout_cfg = tmo;
    open_cfg = open_d;
    cfg_writes++;
  endtask

  task automatic run_random_block(int n_items);
    int          start;
    int          nov;
    logic [15:0] cap1;
    start = sent_count;
    while (sent_count - start < n_items) begin
      if ($urandom_range(99, 0) < 25) begin
        send_event(2'($urandom_range(3, 0)), 16'($urandom));
      end else begin
        send_event(OP_TRIGGER, 16'($urandom));
        repeat ($urandom_range(2, 0)) send_event(OP_TICK, 16'($urandom));
        cap1 = 16'($urandom);
        send_event(OP_CAPTURE, cap1);
        nov = $urandom_range(3, 0);
        repeat (nov) begin
          send_event(OP_OVERFLOW, 16'($urandom));
          if ($urandom_range(1, 0) == 1) send_event(OP_TICK, 16'($urandom));
        end
        if ($urandom_range(99, 0) < 30 && timeout_cfg <= 10'd40) begin
          repeat (int'(timeout_cfg) + 1) send_event(OP_TICK, 16'($urandom));
        end else if ($urandom_range(1, 0) == 1) begin
          send_event(OP_CAPTURE, cap1 + 16'($urandom_range(26500, 0)));
        end else begin
          send_event(OP_CAPTURE, 16'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.distance = out_ch.distance;
      got.measure_done = out_ch.measure_done;
      got.timed_out = out_ch.timed_out;
      got.trigger_fired = out_ch.trigger_fired;
      got.busy_res = out_ch.busy_res;
      got.edge_phase = out_ch.edge_phase;
      if (expected_ranges.size() == 0) begin
        $display("%0t: result transaction with none expected: expected none, actual %0d",
                 $time, got.distance);
        err_count++;
      end else begin
        want = expected_ranges.pop_front();
        checked_count++;
        if (want.measure_done) done_count++;
        if (want.timed_out) timeout_count++;
        field_check("distance", want.distance, got.distance);
        field_check("measure_done", 16'(want.measure_done), 16'(got.measure_done));
        field_check("timed_out", 16'(want.timed_out), 16'(got.timed_out));
        field_check("trigger_fired", 16'(want.trigger_fired), 16'(got.trigger_fired));
        field_check("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        field_check("edge_phase", 16'(want.edge_phase), 16'(got.edge_phase));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_ranges.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int k;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_TRIGGER;
    in_ch.capture_value <= '0;
    awaiting_fall = 1'b0;
    rise_ts = '0;
    ovf_cnt = '0;
    armed = 1'b0;
    ms_elapsed = '0;
    dist_q = '0;
    wrap_cfg = WRAP_RESET;
    timeout_cfg = TIMEOUT_RESET;
    open_cfg = OPEN_RESET;

    dir_rows = '{
      ev_row_x(OP_TICK, 16'h0000, out_item_t'{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}),
      ev_row_x(OP_TRIGGER, 16'hFFFF, out_item_t'{16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}),
      ev_row_x(OP_TRIGGER, 16'h0000, out_item_t'{16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}),
      ev_row_x(OP_CAPTURE, 16'h0000, out_item_t'{16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}),
      ev_row_x(OP_CAPTURE, 16'hFFFF, out_item_t'{16'd45000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}),
      ev_row(OP_CAPTURE, 16'd1000),
      ev_row(OP_OVERFLOW, 16'h5A5A),
      ev_row(OP_CAPTURE, 16'd999),
      cfg_row(17'd1, 10'd1, 16'hFFFF),
      ev_row(OP_TRIGGER, 16'hA5A5),
      ev_row(OP_CAPTURE, 16'h8000),
      ev_row(OP_OVERFLOW, 16'h0000),
      ev_row(OP_CAPTURE, 16'h7FFF),
      ev_row(OP_CAPTURE, 16'd10),
      ev_row(OP_CAPTURE, 16'd5),
      ev_row(OP_TRIGGER, 16'h0000),
      ev_row(OP_CAPTURE, 16'd3),
      ev_row_x(OP_TICK, 16'h0000, out_item_t'{16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}),
      ev_row(OP_TICK, 16'hFFFF),
      cfg_row(17'd65536, 10'd1000, 16'd0),
      ev_row(OP_CAPTURE, 16'd0),
      ev_row(OP_CAPTURE, 16'd26470),
      ev_row(OP_CAPTURE, 16'd0),
      ev_row(OP_CAPTURE, 16'd26472),
      ev_row(OP_CAPTURE, 16'd0),
      ev_row(OP_OVERFLOW, 16'd0),
      ev_row(OP_CAPTURE, 16'd0)
    };

    send_idle_pct = 13;
    recv_idle_pct = 47;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_regs(dir_rows[i].wrap, dir_rows[i].tmo, dir_rows[i].open_d);
      end else begin
        send_event(dir_rows[i].op, dir_rows[i].cap, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    for (k = 0; k < 6; k++) begin
      wait_idle();
      if (k == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 13;
      end else if (k == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k % 3)
        0: write_regs(17'd1, 10'd1, 16'd0);
        1: write_regs(17'd65536, 10'd1000, 16'hFFFF);
        default: write_regs(17'($urandom_range(65536, 1)), 10'($urandom_range(40, 2)),
                            16'($urandom));
      endcase
      if (k == 1) begin
        send_event(OP_TRIGGER, 16'($urandom));
        repeat (int'(timeout_cfg)) send_event(OP_TICK, 16'($urandom));
      end
      run_random_block(BLOCK_ITEMS);
    end

    wait_idle();
    $display("Covered %0d timer events and %0d result transactions:", sent_count,
             checked_count);
    $display("%0d measurements, %0d timeouts, %0d register settings, three idle patterns.",
             done_count, timeout_count, cfg_writes);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
